### design/dwsd_pkg.sv
// ----------------------------------------------------------------------------
// dwsd_pkg: shared types and constants
// Sample width and the control bundle that steers the statistics unit.
// ----------------------------------------------------------------------------
package dwsd_pkg;

  // converter sample width
  localparam int unsigned SAMPLE_W = 16;

  // value that starts a running minimum
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

  // control from the sequencer to the statistics unit
  typedef struct packed {
    logic clear;  // start a new window
    logic acc;    // fold one window entry into min, max and sum
    logic div;    // scale the window sum down to the mean
  } stats_ctrl_t;

endpackage

### design/dwsd_cell.sv
// ----------------------------------------------------------------------------
// dwsd_cell: one history cell
// Holds one sample and takes its neighbor's value when enabled.
// ----------------------------------------------------------------------------
module dwsd_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [dwsd_pkg::SAMPLE_W-1:0] d,
  output logic [dwsd_pkg::SAMPLE_W-1:0] q
);

  logic [dwsd_pkg::SAMPLE_W-1:0] data_r;

  // history is cleared to zero at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else if (en) begin
      data_r <= d;
    end
  end

  assign q = data_r;

endmodule

### design/dwsd_stats.sv
// ----------------------------------------------------------------------------
// dwsd_stats: window statistics unit
// Running min, max and sum over streamed entries, then a registered
// reciprocal multiply that turns the sum into the truncated mean.
// ----------------------------------------------------------------------------
module dwsd_stats #(
  parameter int unsigned WIN_LEN = 128
) (
  input  logic                          clk,
  input  dwsd_pkg::stats_ctrl_t         ctrl,
  input  logic [dwsd_pkg::SAMPLE_W-1:0] value,
  output logic [dwsd_pkg::SAMPLE_W-1:0] win_min,
  output logic [dwsd_pkg::SAMPLE_W-1:0] win_max,
  output logic [dwsd_pkg::SAMPLE_W-1:0] win_mean
);

  localparam int unsigned SUM_W   = dwsd_pkg::SAMPLE_W + $clog2(WIN_LEN);
  // floor(sum / WIN_LEN) = (sum * RECIP) >> DIV_SH for every sum below 2^SUM_W
  localparam int unsigned DIV_SH  = SUM_W + $clog2(WIN_LEN);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(WIN_LEN) - 64'd1) / 64'(WIN_LEN));

  logic [dwsd_pkg::SAMPLE_W-1:0] min_r, min_nxt;
  logic [dwsd_pkg::SAMPLE_W-1:0] max_r, max_nxt;
  logic [SUM_W-1:0]              sum_r, sum_nxt;
  logic [PROD_W-1:0]             prod;

  // sum times the scaled reciprocal of the window length
  assign prod = PROD_W'(sum_r) * PROD_W'(RECIP);

  // next values for clear, accumulate and divide steps
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    if (ctrl.clear) begin
      min_nxt = dwsd_pkg::SAMPLE_MAX;
      max_nxt = '0;
      sum_nxt = '0;
    end else if (ctrl.acc) begin
      if (value < min_r) min_nxt = value;
      if (value > max_r) max_nxt = value;
      sum_nxt = sum_r + SUM_W'(value);
    end else if (ctrl.div) begin
      // sum register takes the quotient
      sum_nxt = {{(SUM_W-dwsd_pkg::SAMPLE_W){1'b0}},
                 prod[DIV_SH +: dwsd_pkg::SAMPLE_W]};
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    min_r <= min_nxt;
    max_r <= max_nxt;
    sum_r <= sum_nxt;
  end

  // quotient never exceeds the sample range
  assign win_min  = min_r;
  assign win_max  = max_r;
  assign win_mean = sum_r[dwsd_pkg::SAMPLE_W-1:0];

endmodule

### design/delayed_window_stats_drop_detect.sv
// ----------------------------------------------------------------------------
// delayed_window_stats_drop_detect: delayed window statistics, drop detector
// Keeps a sample history and reports min, max and mean of its older half,
// flagging a drop when the new sample falls far enough below that mean.
// ----------------------------------------------------------------------------
// The history is a chain of HISTORY_DEPTH cells, cleared to zero by reset.
// An accepted request shifts its sample into the head of the chain; the
// older half of the chain (the window) then rotates once around itself, one
// entry per cycle, into the min/max/sum unit, and a divide step then turns
// the sum into the mean with a constant reciprocal multiply. The window is
// HISTORY_DEPTH/2 entries long (128 at the default depth of 256). The result
// enters the output register once that register is free, and only then is
// the next request taken. Only one request is worked on at a time; a
// finished result waits in the output register while the next request is
// taken.
// ----------------------------------------------------------------------------
module delayed_window_stats_drop_detect #(
  parameter int unsigned HISTORY_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: drop threshold
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [15:0] window_min, [31:16] window_mean,
                                  // [47:32] window_max, [48] drop_detected,
                                  // [55:49] zero
);

  localparam int unsigned SW      = dwsd_pkg::SAMPLE_W;
  localparam int unsigned WIN_LEN = HISTORY_DEPTH / 2;
  localparam int unsigned NEW_N   = HISTORY_DEPTH - WIN_LEN;
  localparam int unsigned CNT_W   = $clog2(WIN_LEN);
  localparam logic [15:0] THR_RESET = 16'd128;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [SW-1:0]          sample_r;
  logic [15:0]            thr_r;
  logic                   out_valid_r;
  logic [SW-1:0]          min_out_r, mean_out_r, max_out_r;
  logic                   drop_out_r;

  logic                   accept;
  logic                   shift;
  logic                   rotate;
  logic                   out_free;
  logic                   drop;
  dwsd_pkg::stats_ctrl_t  ctrl;
  logic [SW-1:0]          win_min, win_max, win_mean;
  logic [SW-1:0]          cell_q [HISTORY_DEPTH];

  // handshake
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // chain control
  assign shift  = accept;
  assign rotate = (state_r == S_SCAN);

  // statistics unit control
  assign ctrl.clear = accept;
  assign ctrl.acc   = (state_r == S_SCAN);
  assign ctrl.div   = (state_r == S_DIV);

  // history chain: newer part shifts only, window part also rotates
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    logic [SW-1:0] d;
    logic          en;
    if (i == 0) begin : g_head
      assign d  = in_tdata;
      assign en = shift;
    end else if (i == NEW_N) begin : g_win_head
      assign d  = rotate ? cell_q[HISTORY_DEPTH-1] : cell_q[i-1];
      assign en = shift || rotate;
    end else if (i > NEW_N) begin : g_win
      assign d  = cell_q[i-1];
      assign en = shift || rotate;
    end else begin : g_new
      assign d  = cell_q[i-1];
      assign en = shift;
    end
    dwsd_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (d),
      .q     (cell_q[i])
    );
  end

  dwsd_stats #(
    .WIN_LEN (WIN_LEN)
  ) u_stats (
    .clk      (clk),
    .ctrl     (ctrl),
    .value    (cell_q[HISTORY_DEPTH-1]),
    .win_min  (win_min),
    .win_max  (win_max),
    .win_mean (win_mean)
  );

  // drop when mean - sample >= threshold
  assign drop = ({1'b0, win_mean} >= ({1'b0, sample_r} + {1'b0, thr_r}));

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            sample_r <= in_tdata;
            cnt_r    <= '0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r == CNT_W'(WIN_LEN - 1)) begin
            cnt_r   <= '0;
            state_r <= S_DIV;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_DIV: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            min_out_r   <= win_min;
            mean_out_r  <= win_mean;
            max_out_r   <= win_max;
            drop_out_r  <= drop;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, drop_out_r, max_out_r, mean_out_r, min_out_r};

`ifndef ASSERT_OFF
  // an accepted request always starts the window scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN))
    else $error("accepted request did not start the scan");

  // scan counter stays inside the window
  a_scan_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= CNT_W'(WIN_LEN - 1)))
    else $error("scan counter ran past the window");

  // a finished result waits while the output register is occupied
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DONE) && out_valid_r && !out_tready) |=> (state_r == S_DONE))
    else $error("result overwrote a pending output");

  // statistics unit gets at most one command per cycle
  a_ctrl_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.clear, ctrl.acc, ctrl.div}))
    else $error("conflicting statistics commands");
`endif

endmodule
